// ===== rtl/assert_macros.svh =====
// assertion macros shared by the alu rtl
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define XAF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define XAF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/xaf_pkg.sv =====
// shared types and codes for the x86 alu with flags
// no dependencies
package xaf_pkg;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_ADC  = 4'd1,
      OP_SUB  = 4'd2,
      OP_SBB  = 4'd3,
      OP_AND  = 4'd4,
      OP_OR   = 4'd5,
      OP_XOR  = 4'd6,
      OP_SHL  = 4'd7,
      OP_SAL  = 4'd8,
      OP_SHR  = 4'd9,
      OP_SAR  = 4'd10,
      OP_MUL  = 4'd11,
      OP_IMUL = 4'd12
   } op_type;

   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;

   typedef struct packed {
      logic cf;
      logic of;
      logic sf;
      logic zf;
      logic pf;
   } flags_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] src_operand;
      logic [31:0] dest_operand;
      logic [1:0]  size_code;
   } req_item_type;

endpackage

// ===== rtl/xaf_channels.sv =====
// valid/ready channel interfaces for the request and response sides
// no dependencies
interface xaf_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  op;
   logic [31:0] src_operand;
   logic [31:0] dest_operand;
   logic [1:0]  size_code;

   modport source (output valid, op, src_operand, dest_operand, size_code, input ready);
   modport sink (input valid, op, src_operand, dest_operand, size_code, output ready);
endinterface

interface xaf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result;
   logic        carry_out;
   logic        overflow_out;
   logic        sign_out;
   logic        zero_out;
   logic        parity_out;

   modport source (output valid, result, carry_out, overflow_out, sign_out, zero_out,
                   parity_out, input ready);
   modport sink (input valid, result, carry_out, overflow_out, sign_out, zero_out,
                 parity_out, output ready);
endinterface

// ===== rtl/xaf_exec.sv =====
// single-pass alu datapath: add/sub, logic, shifts, multiplies and flag rules
// depends on xaf_pkg
module xaf_exec
   import xaf_pkg::*;
(
   input  req_item_type item,
   input  flags_type    flags_cur,
   output logic [63:0]  result,
   output flags_type    flags_nxt
);

   logic [31:0]        mask;
   logic [31:0]        msb;
   logic [31:0]        st;
   logic [31:0]        dt;
   logic               cin;
   logic [4:0]         cnt;
   logic [32:0]        sum33;
   logic [32:0]        sub_rhs;
   logic [32:0]        diff33;
   logic [63:0]        shl64;
   logic [32:0]        shr33;
   logic [31:0]        dt_sext;
   logic [31:0]        st_sext;
   logic signed [32:0] sar_src;
   logic [32:0]        sar33;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod;
   logic [63:0]        p;
   logic [31:0]        p_low;
   logic [63:0]        p_sext;
   logic [63:0]        imul_mask;
   logic               mul_hi;
   logic [31:0]        r;
   logic               upd_szp;

   always_comb begin
      case (item.size_code)
         SIZE_8: begin
            mask      = 32'h0000_00FF;
            msb       = 32'h0000_0080;
            imul_mask = 64'h0000_0000_0000_FFFF;
         end
         SIZE_16: begin
            mask      = 32'h0000_FFFF;
            msb       = 32'h0000_8000;
            imul_mask = 64'h0000_0000_FFFF_FFFF;
         end
         default: begin
            mask      = 32'hFFFF_FFFF;
            msb       = 32'h8000_0000;
            imul_mask = 64'hFFFF_FFFF_FFFF_FFFF;
         end
      endcase
   end

   assign st  = item.src_operand & mask;
   assign dt  = item.dest_operand & mask;
   assign cnt = item.src_operand[4:0];
   assign cin = ((item.op == OP_ADC) || (item.op == OP_SBB)) ? flags_cur.cf : 1'b0;

   assign sum33   = {1'b0, dt} + {1'b0, st} + {32'b0, cin};
   assign sub_rhs = {1'b0, st} + {32'b0, cin};
   assign diff33  = {1'b0, dt} - sub_rhs;

   // shifted-out bit lands in bit 0 (right) or bit n (left)
   assign shl64   = {32'b0, dt} << cnt;
   assign shr33   = {dt, 1'b0} >> cnt;
   assign dt_sext = ((dt & msb) != 32'b0) ? (dt | ~mask) : dt;
   assign st_sext = ((st & msb) != 32'b0) ? (st | ~mask) : st;
   assign sar_src = {dt_sext, 1'b0};
   assign sar33   = sar_src >>> cnt;

   assign mul_a  = (item.op == OP_IMUL) ? {dt_sext[31], dt_sext} : {1'b0, dt};
   assign mul_b  = (item.op == OP_IMUL) ? {st_sext[31], st_sext} : {1'b0, st};
   assign prod   = mul_a * mul_b;
   assign p      = prod[63:0];
   assign p_low  = p[31:0] & mask;
   assign p_sext = ((p_low & msb) != 32'b0) ? {32'hFFFF_FFFF, p_low | ~mask}
                                            : {32'b0, p_low};
   assign mul_hi = (p & ~{32'b0, mask}) != 64'b0;

   always_comb begin
      flags_nxt = flags_cur;
      r         = 32'b0;
      result    = 64'b0;
      upd_szp   = 1'b0;
      case (item.op) inside
         OP_ADD, OP_ADC: begin
            r = sum33[31:0] & mask;
            case (item.size_code)
               SIZE_8:  flags_nxt.cf = sum33[8];
               SIZE_16: flags_nxt.cf = sum33[16];
               default: flags_nxt.cf = sum33[32];
            endcase
            flags_nxt.of = |(~(dt ^ st) & (dt ^ r) & msb);
            upd_szp      = 1'b1;
         end
         OP_SUB, OP_SBB: begin
            r            = diff33[31:0] & mask;
            flags_nxt.cf = diff33[32];
            flags_nxt.of = |((dt ^ st) & (dt ^ r) & msb);
            upd_szp      = 1'b1;
         end
         OP_AND, OP_OR, OP_XOR: begin
            case (item.op)
               OP_AND:  r = dt & st;
               OP_OR:   r = dt | st;
               default: r = dt ^ st;
            endcase
            flags_nxt.cf = 1'b0;
            flags_nxt.of = 1'b0;
            upd_szp      = 1'b1;
         end
         OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
            // zero count passes the operand through and keeps every flag
            if (cnt == 5'd0) begin
               r = dt;
            end else begin
               upd_szp = 1'b1;
               case (item.op)
                  OP_SHR: begin
                     r            = shr33[32:1];
                     flags_nxt.cf = shr33[0];
                  end
                  OP_SAR: begin
                     r            = sar33[32:1] & mask;
                     flags_nxt.cf = sar33[0];
                  end
                  default: begin
                     r = shl64[31:0] & mask;
                     case (item.size_code)
                        SIZE_8:  flags_nxt.cf = shl64[8];
                        SIZE_16: flags_nxt.cf = shl64[16];
                        default: flags_nxt.cf = shl64[32];
                     endcase
                  end
               endcase
            end
         end
         OP_MUL: begin
            flags_nxt.cf = mul_hi;
            flags_nxt.of = mul_hi;
         end
         OP_IMUL: begin
            flags_nxt.cf = (p != p_sext);
            flags_nxt.of = (p != p_sext);
         end
         default: begin
            r = 32'b0;
         end
      endcase

      case (item.op)
         OP_MUL:  result = p;
         OP_IMUL: result = p & imul_mask;
         default: result = {32'b0, r};
      endcase

      if (upd_szp) begin
         flags_nxt.zf = (r == 32'b0);
         flags_nxt.sf = |(r & msb);
         flags_nxt.pf = ~^r[7:0];
      end
   end

endmodule

// ===== rtl/x86_alu_with_flags_core.sv =====
// top level: request register, alu datapath, flag state and response register
// depends on xaf_pkg, xaf_channels, xaf_exec and assert_macros.svh
//
// One operation is accepted per clock cycle while the response side is not stalled.
// It passes from the request register through the combinational datapath into the
// response register. Throughput is one beat per cycle unless the response stalls; the
// longest path of the datapath is the 33x33 multiplier and its overflow compare.
// The stored CF/OF/SF/ZF/PF flags are updated as each operation moves into the
// response register, so a dependent adc or sbb may follow the previous beat
// directly. A stalled response holds the pipeline; no beat is dropped.
`include "assert_macros.svh"

module x86_alu_with_flags_core
   import xaf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   xaf_req_if.sink   req_chan,
   xaf_rsp_if.source rsp_chan
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   req_item_type s1_item_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic [63:0]  out_result_ff;
   logic [63:0]  out_result_in;
   flags_type    flags_ff;
   flags_type    flags_in;
   logic [63:0]  exec_result;
   flags_type    exec_flags;
   logic         advance;
   logic         req_fire;

   xaf_exec u_exec (
      .item      (s1_item_ff),
      .flags_cur (flags_ff),
      .result    (exec_result),
      .flags_nxt (exec_flags)
   );

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in   = req_chan.ready ? req_chan.valid : s1_valid_ff;
      s1_item_in    = s1_item_ff;
      if (req_fire) begin
         s1_item_in.op           = req_chan.op;
         s1_item_in.src_operand  = req_chan.src_operand;
         s1_item_in.dest_operand = req_chan.dest_operand;
         s1_item_in.size_code    = req_chan.size_code;
      end
      out_valid_in  = advance ? 1'b1 : (out_valid_ff && !rsp_chan.ready);
      out_result_in = advance ? exec_result : out_result_ff;
      flags_in      = advance ? exec_flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      out_result_ff <= out_result_in;
   end

   // flags on the response beat are the stored flag state
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result       = out_result_ff;
   assign rsp_chan.carry_out    = flags_ff.cf;
   assign rsp_chan.overflow_out = flags_ff.of;
   assign rsp_chan.sign_out     = flags_ff.sf;
   assign rsp_chan.zero_out     = flags_ff.zf;
   assign rsp_chan.parity_out   = flags_ff.pf;

   `XAF_ASSERT_NXT(a_flags_hold_on_stall, out_valid_ff && !rsp_chan.ready,
      $stable(flags_ff), "flags changed while response stalled")
   `XAF_ASSERT_NXT(a_s1_kept_on_stall, s1_valid_ff && out_valid_ff && !rsp_chan.ready,
      s1_valid_ff, "pending operation lost during stall")
   `XAF_ASSERT_NXT(a_logic_clears_cf_of,
      advance && (s1_item_ff.op == OP_AND || s1_item_ff.op == OP_OR ||
                  s1_item_ff.op == OP_XOR),
      out_valid_ff && !flags_ff.cf && !flags_ff.of, "logic op left cf or of set")
   `XAF_ASSERT_NXT(a_no_advance_keeps_flags, !advance, $stable(flags_ff),
      "flags changed without an operation")

endmodule

// ===== verif/tb_x86_alu_with_flags_core.sv =====
// testbench for x86_alu_with_flags_core: directed table then random operations, with an
// in-bench flag-keeping alu predictor checking every response beat in order, except that
// directed rows that give expected values are checked against those; depends on xaf_pkg, xaf_channels and the core rtl
module tb_x86_alu_with_flags_core;
   import xaf_pkg::*;

   localparam logic [1:0] SIZE_32      = 2'd2;
   localparam logic [1:0] SIZE_ALIAS32 = 2'd3;
   localparam logic [3:0] OP_UNUSED_LO = 4'd13;
   localparam logic [3:0] OP_CODE_MAX  = 4'd15;
   localparam int RANDOM_ITEMS = 500;
   localparam int CALM_FROM    = 420;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [63:0] result;
      flags_type   flags;
   } alu_rsp_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] src;
      logic [31:0] dest;
      logic [1:0]  size;
      logic        has_want;
      logic [63:0] want_result;
      flags_type   want_flags;
   } stim_row_type;

   // flags columns are cf of sf zf pf
   localparam int DIRECTED_ROWS = 25;
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{OP_ADD,  32'h0000_0000, 32'h0000_0000, SIZE_8,       1'b1, 64'h0,        5'b00011},
      '{OP_ADD,  32'h0000_0001, 32'h0000_00FF, SIZE_8,       1'b1, 64'h0,        5'b10011},
      '{OP_ADC,  32'h0000_0000, 32'h0000_0000, SIZE_8,       1'b1, 64'h1,        5'b00000},
      '{OP_ADD,  32'h0000_0001, 32'h0000_7FFF, SIZE_16,      1'b1, 64'h8000,     5'b01101},
      '{OP_SUB,  32'h0000_0001, 32'h0000_0000, SIZE_32,      1'b1, 64'hFFFF_FFFF, 5'b10101},
      '{OP_SBB,  32'hFFFF_FFFF, 32'h0000_0000, SIZE_32,      1'b1, 64'h0,        5'b10011},
      '{OP_SUB,  32'h0000_0001, 32'h0000_0080, SIZE_8,       1'b1, 64'h7F,       5'b01000},
      '{OP_ADC,  32'h0000_007F, 32'h0000_007F, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_AND,  32'h0000_0000, 32'hFFFF_FFFF, SIZE_32,      1'b1, 64'h0,        5'b00011},
      '{OP_OR,   32'h8000_0000, 32'h0000_0001, SIZE_32,      1'b0, 64'h0,        5'b00000},
      '{OP_XOR,  32'h0000_FFFF, 32'h0000_FFFF, SIZE_16,      1'b0, 64'h0,        5'b00000},
      '{OP_SHL,  32'hFFFF_FFE0, 32'hFFFF_FFFF, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_SHL,  32'h0000_0008, 32'h0000_0001, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_SAL,  32'h0000_001F, 32'h0000_00FF, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_SHR,  32'h0000_0010, 32'h0000_8000, SIZE_16,      1'b0, 64'h0,        5'b00000},
      '{OP_SHR,  32'h0000_001F, 32'h0000_FFFF, SIZE_16,      1'b0, 64'h0,        5'b00000},
      '{OP_SAR,  32'h0000_001F, 32'h0000_0080, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_SAR,  32'hFFFF_FFE1, 32'h8000_0001, SIZE_32,      1'b0, 64'h0,        5'b00000},
      '{OP_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_32,      1'b0, 64'h0,        5'b00000},
      '{OP_MUL,  32'h0000_0002, 32'h0000_0003, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_IMUL, 32'h0000_0080, 32'h0000_0080, SIZE_8,       1'b0, 64'h0,        5'b00000},
      '{OP_IMUL, 32'h0000_FFFF, 32'h0000_FFFF, SIZE_16,      1'b0, 64'h0,        5'b00000},
      '{OP_IMUL, 32'h8000_0000, 32'h7FFF_FFFF, SIZE_32,      1'b0, 64'h0,        5'b00000},
      '{OP_CODE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_32,  1'b0, 64'h0,        5'b00000},
      '{OP_ADD,  32'hFFFF_FFFF, 32'h0000_0001, SIZE_ALIAS32, 1'b0, 64'h0,        5'b00000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   xaf_req_if req_chan();
   xaf_rsp_if rsp_chan();

   x86_alu_with_flags_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   flags_type   arch_flags;
   alu_rsp_type pending_results [$];
   logic        row_has_want = 1'b0;
   alu_rsp_type row_want = '0;
   logic        calm = 1'b0;
   logic        gaps_on = 1'b0;
   int          mismatches = 0;
   int          rsp_beats = 0;
   int          cycles = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 200)
         $display("mismatch at beat %0d on %s: got %h, want %h", rsp_beats, what, got, want);
   endtask

   function automatic void take_result_flags(input logic [31:0] r, input logic [31:0] mask,
                                             input logic [31:0] msb);
      arch_flags.zf = ((r & mask) == 32'h0);
      arch_flags.sf = ((r & msb) != 32'h0);
      arch_flags.pf = ~^r[7:0];
   endfunction

   // one alu operation against the flag copy; updates it like the hardware does
   function automatic alu_rsp_type exec_alu(input logic [3:0] op, input logic [31:0] src,
                                            input logic [31:0] dest, input logic [1:0] size);
      int unsigned n;
      logic [31:0] mask, msb, s_t, d_t, r, v;
      logic [63:0] wide, dbl_mask;
      logic [4:0]  cnt;
      logic        cin;
      longint      sa, sb, prod, lim;
      alu_rsp_type res;
      n = (size == SIZE_8) ? 8 : ((size == SIZE_16) ? 16 : 32);
      mask = (n == 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
      msb = 32'h1 << (n - 1);
      s_t = src & mask;
      d_t = dest & mask;
      cin = arch_flags.cf;
      cnt = src[4:0];
      res.result = '0;
      case (op)
         OP_ADD, OP_ADC: begin
            wide = 64'(d_t) + 64'(s_t) + ((op == OP_ADC) ? 64'(cin) : 64'd0);
            r = wide[31:0] & mask;
            arch_flags.cf = wide[n];
            arch_flags.of = |(~(d_t ^ s_t) & (d_t ^ r) & msb);
            take_result_flags(r, mask, msb);
            res.result = 64'(r);
         end
         OP_SUB, OP_SBB: begin
            // borrow counts the stored carry on top of the full source
            wide = 64'(s_t) + ((op == OP_SBB) ? 64'(cin) : 64'd0);
            r = 32'(64'(d_t) - wide) & mask;
            arch_flags.cf = (64'(d_t) < wide);
            arch_flags.of = |((d_t ^ s_t) & (d_t ^ r) & msb);
            take_result_flags(r, mask, msb);
            res.result = 64'(r);
         end
         OP_AND, OP_OR, OP_XOR: begin
            r = (op == OP_AND) ? (d_t & s_t) : ((op == OP_OR) ? (d_t | s_t) : (d_t ^ s_t));
            arch_flags.cf = 1'b0;
            arch_flags.of = 1'b0;
            take_result_flags(r, mask, msb);
            res.result = 64'(r);
         end
         OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
            if (cnt == 5'd0) begin
               res.result = 64'(d_t);
            end else begin
               if (op == OP_SHR) begin
                  r = d_t >> cnt;
                  arch_flags.cf = d_t[cnt - 5'd1];
               end else if (op == OP_SAR) begin
                  v = ((d_t & msb) != 32'h0) ? (d_t | ~mask) : d_t;
                  r = $signed(v) >>> cnt;
                  r = r & mask;
                  arch_flags.cf = v[cnt - 5'd1];
               end else begin
                  r = (d_t << cnt) & mask;
                  arch_flags.cf = (cnt <= n) ? d_t[n - cnt] : 1'b0;
               end
               take_result_flags(r, mask, msb);
               res.result = 64'(r);
            end
         end
         OP_MUL: begin
            wide = 64'(d_t) * 64'(s_t);
            arch_flags.cf = ((wide >> n) != 64'h0);
            arch_flags.of = arch_flags.cf;
            res.result = wide;
         end
         OP_IMUL: begin
            sa = longint'(d_t);
            sb = longint'(s_t);
            if ((d_t & msb) != 32'h0) sa -= longint'(64'h1 << n);
            if ((s_t & msb) != 32'h0) sb -= longint'(64'h1 << n);
            prod = sa * sb;
            lim = longint'(64'h1 << (n - 1));
            dbl_mask = (n == 32) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'h1 << (2 * n)) - 64'h1);
            arch_flags.cf = (prod < -lim) || (prod >= lim);
            arch_flags.of = arch_flags.cf;
            res.result = 64'(prod) & dbl_mask;
         end
         default: res.result = '0;
      endcase
      res.flags = arch_flags;
      return res;
   endfunction

   // predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      alu_rsp_type pred, want;
      if (reset) begin
         arch_flags = '0;
         pending_results.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pred = exec_alu(req_chan.op, req_chan.src_operand, req_chan.dest_operand,
                            req_chan.size_code);
            pending_results.push_back(row_has_want ? row_want : pred);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", rsp_chan.result, 64'h0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.result !== want.result)
                  report_mismatch("result", rsp_chan.result, want.result);
               if (rsp_chan.carry_out !== want.flags.cf)
                  report_mismatch("carry_out", 64'(rsp_chan.carry_out), 64'(want.flags.cf));
               if (rsp_chan.overflow_out !== want.flags.of)
                  report_mismatch("overflow_out", 64'(rsp_chan.overflow_out), 64'(want.flags.of));
               if (rsp_chan.sign_out !== want.flags.sf)
                  report_mismatch("sign_out", 64'(rsp_chan.sign_out), 64'(want.flags.sf));
               if (rsp_chan.zero_out !== want.flags.zf)
                  report_mismatch("zero_out", 64'(rsp_chan.zero_out), 64'(want.flags.zf));
               if (rsp_chan.parity_out !== want.flags.pf)
                  report_mismatch("parity_out", 64'(rsp_chan.parity_out), 64'(want.flags.pf));
            end
            rsp_beats++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_x86_alu_with_flags_core: errors");
         $finish;
      end
   end

   // response backpressure in bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0 && !calm) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_chan.ready <= 1'b0;
         end else begin
            stall_left = 0;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_op(input logic [3:0] op, input logic [31:0] src, input logic [31:0] dest,
                          input logic [1:0] size, input logic has_want,
                          input alu_rsp_type want);
      if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 5)) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.src_operand  <= src;
      req_chan.dest_operand <= dest;
      req_chan.size_code    <= size;
      row_has_want          <= has_want;
      row_want              <= want;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic [31:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h80 << ((sel == 0) ? 0 : ((sel == 1) ? 8 : 24));
         3: return (32'h80 << ((sel == 0) ? 0 : ((sel == 1) ? 8 : 24))) - 32'h1;
         4: return 32'($urandom_range(0, 3));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_shift_src(input logic [1:0] size);
      int n;
      logic [4:0] cnt;
      n = (size == SIZE_8) ? 8 : ((size == SIZE_16) ? 16 : 32);
      case ($urandom_range(0, 7))
         0: cnt = 5'd0;
         1: cnt = 5'd1;
         2: cnt = 5'(n - 1);
         3: cnt = 5'(n);
         4: cnt = 5'(n + 1);
         5: cnt = 5'd31;
         default: cnt = 5'($urandom_range(0, 31));
      endcase
      return ($urandom() & ~32'h1F) | 32'(cnt);
   endfunction

   function automatic logic [1:0] pick_size();
      return ($urandom_range(0, 9) == 0) ? SIZE_ALIAS32 : 2'($urandom_range(SIZE_8, SIZE_32));
   endfunction

   initial begin
      int sent, chain_len;
      logic [3:0] op;
      logic [1:0] size;
      logic [31:0] src;
      alu_rsp_type want;
      req_chan.valid = 1'b0;
      req_chan.op = OP_ADD;
      req_chan.src_operand = '0;
      req_chan.dest_operand = '0;
      req_chan.size_code = SIZE_8;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gaps_on = 1'b1;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         want.result = directed_rows[i].want_result;
         want.flags  = directed_rows[i].want_flags;
         send_op(directed_rows[i].op, directed_rows[i].src, directed_rows[i].dest,
                 directed_rows[i].size, directed_rows[i].has_want, want);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // quiet stretch at the start of every hundred, and quiet from CALM_FROM to the end
         gaps_on = ((sent % 100) >= 25);
         calm = (sent >= CALM_FROM);
         size = pick_size();
         if ($urandom_range(0, 4) == 0) begin
            // multi-word add or subtract: low word then carry-chained words
            op = $urandom_range(0, 1) ? OP_ADD : OP_SUB;
            send_op(op, pick_operand(), pick_operand(), size, 1'b0, '0);
            sent++;
            chain_len = $urandom_range(1, 3);
            repeat (chain_len) begin
               send_op((op == OP_ADD) ? OP_ADC : OP_SBB, pick_operand(), pick_operand(),
                       size, 1'b0, '0);
               sent++;
            end
         end else begin
            if ($urandom_range(0, 19) == 0)
               op = 4'($urandom_range(OP_UNUSED_LO, OP_CODE_MAX));
            else
               op = 4'($urandom_range(OP_ADD, OP_IMUL));
            if (op == OP_SHL || op == OP_SAL || op == OP_SHR || op == OP_SAR)
               src = pick_shift_src(size);
            else
               src = pick_operand();
            send_op(op, src, pick_operand(), size, 1'b0, '0);
            sent++;
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
      calm = 1'b1;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_x86_alu_with_flags_core: clean");
      else
         $display("tb_x86_alu_with_flags_core: errors");
      $finish;
   end

endmodule
